/* rtl/wds_pkg.sv */
// Shared constants, types and codes for the weighted dose statistics block.
package wds_pkg;

    localparam int MAX_POSITIONS   = 8;
    localparam int MAX_VOXELS_LOG2 = 16;

    localparam int DOSE_W    = 16;
    localparam int FRAC_W    = 13;
    localparam int ID_W      = 32;
    localparam int SUM_W     = 29 + MAX_VOXELS_LOG2;
    localparam int SQ_W      = 45 + MAX_VOXELS_LOG2;
    localparam int FSUM_W    = FRAC_W + MAX_VOXELS_LOG2;
    localparam int WCNT_W    = 29;
    localparam int VOL_W     = 32;
    localparam int VVOL_W    = 16;
    localparam int FLOOR_W   = 32;
    localparam int WANT_W    = 4;
    localparam int PROD_W    = 2 * SUM_W;
    localparam int DVS_W     = 2 * FSUM_W;
    localparam int MP_W      = SUM_W;
    localparam int STEP_W    = $clog2(PROD_W + 1);
    localparam int POS_IDX_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int POS_CNT_W = $clog2(MAX_POSITIONS + 1);
    localparam int EMIT_W    = $clog2(2 * MAX_POSITIONS + 2);
    localparam int SQRT_STEPS = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 160;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TWO_VOXELS = 8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WANTED = 2'd0,
        CFG_MAX_WANTED = 2'd1,
        CFG_VOXEL_VOL  = 2'd2,
        CFG_VAR_FLOOR  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_STAT = 2'd0,
        KIND_MIN  = 2'd1,
        KIND_MAX  = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        OP_NONE, OP_TAKE, OP_ACC, OP_MQF_GO, OP_MSS_GO, OP_STEP_MUL, OP_SUB,
        OP_DIVM_GO, OP_STEP_DIV, OP_MEAN, OP_DIVV_GO, OP_SQRT_GO, OP_STEP_SQRT,
        OP_DEV, OP_LOAD, OP_NEXT, OP_CLEAR
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_MQF, S_MQF_RUN, S_MSS_RUN, S_DIVM, S_DIVM_RUN, S_DIVV,
        S_DIVV_RUN, S_SQRT_RUN, S_LOAD, S_SEND
    } t_state;

    typedef struct packed {
        logic last;
        logic done;
        logic emit_last;
    } t_status;

endpackage

/* rtl/wds_ctrl.sv */
// Sequencer for accumulation, final arithmetic and result emission.
module wds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  wds_pkg::t_status i_st,
    output wds_pkg::t_op     o_op
);
    import wds_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = OP_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_TAKE;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_op    = OP_ACC;
                n_state = i_st.last ? S_MQF : S_IDLE;
            end
            S_MQF: begin
                o_op    = OP_MQF_GO;
                n_state = S_MQF_RUN;
            end
            S_MQF_RUN: begin
                if (i_st.done) begin
                    o_op    = OP_MSS_GO;
                    n_state = S_MSS_RUN;
                end else begin
                    o_op = OP_STEP_MUL;
                end
            end
            S_MSS_RUN: begin
                if (i_st.done) begin
                    o_op    = OP_SUB;
                    n_state = S_DIVM;
                end else begin
                    o_op = OP_STEP_MUL;
                end
            end
            S_DIVM: begin
                o_op    = OP_DIVM_GO;
                n_state = S_DIVM_RUN;
            end
            S_DIVM_RUN: begin
                if (i_st.done) begin
                    o_op    = OP_MEAN;
                    n_state = S_DIVV;
                end else begin
                    o_op = OP_STEP_DIV;
                end
            end
            S_DIVV: begin
                o_op    = OP_DIVV_GO;
                n_state = S_DIVV_RUN;
            end
            S_DIVV_RUN: begin
                if (i_st.done) begin
                    o_op    = OP_SQRT_GO;
                    n_state = S_SQRT_RUN;
                end else begin
                    o_op = OP_STEP_DIV;
                end
            end
            S_SQRT_RUN: begin
                if (i_st.done) begin
                    o_op    = OP_DEV;
                    n_state = S_LOAD;
                end else begin
                    o_op = OP_STEP_SQRT;
                end
            end
            S_LOAD: begin
                o_op    = OP_LOAD;
                n_state = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_st.emit_last) begin
                        o_op    = OP_CLEAR;
                        n_state = S_IDLE;
                    end else begin
                        o_op    = OP_NEXT;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/wds_dp.sv */
// Datapath: config registers, accumulators, extremes, shift-add multiplier,
// restoring divider, bit-pair square root and the output word register.
module wds_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [wds_pkg::DOSE_W-1:0]      i_dose,
    input  logic [wds_pkg::FRAC_W-1:0]      i_fraction,
    input  logic [wds_pkg::ID_W-1:0]        i_voxel_id,
    input  logic                            i_last_voxel,
    input  wds_pkg::t_op                    i_op,
    output wds_pkg::t_status                o_st,
    output logic [wds_pkg::OUT_DATA_W-1:0]  o_data,
    output logic [1:0]                      o_kind,
    output logic                            o_last
);
    import wds_pkg::*;

    // configuration
    logic [WANT_W-1:0]  r_min_want, r_max_want;
    logic [VVOL_W-1:0]  r_vvol;
    logic [FLOOR_W-1:0] r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_want <= WANT_W'(8);
            r_max_want <= WANT_W'(8);
            r_vvol     <= '0;
            r_floor    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_WANTED: r_min_want <= i_cfg_data[WANT_W-1:0];
                CFG_MAX_WANTED: r_max_want <= i_cfg_data[WANT_W-1:0];
                CFG_VOXEL_VOL:  r_vvol     <= i_cfg_data[VVOL_W-1:0];
                CFG_VAR_FLOOR:  r_floor    <= i_cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    // input capture with the first products
    logic [DOSE_W-1:0]        r_d;
    logic [FRAC_W-1:0]        r_f;
    logic [ID_W-1:0]          r_id;
    logic                     r_last;
    logic [DOSE_W+FRAC_W-1:0] r_df;
    logic [2*DOSE_W-1:0]      r_dd;

    always_ff @(posedge i_clk) begin
        if (i_op == OP_TAKE) begin
            r_d    <= i_dose;
            r_f    <= i_fraction;
            r_id   <= i_voxel_id;
            r_last <= i_last_voxel;
            r_df   <= i_dose * i_fraction;
            r_dd   <= i_dose * i_dose;
        end
    end

    // run state
    logic [SUM_W-1:0]     r_s;
    logic [SQ_W-1:0]      r_q;
    logic [FSUM_W-1:0]    r_fs;
    logic [DOSE_W-1:0]    r_min, r_max;
    logic                 r_seen;
    logic [ID_W-1:0]      r_min_ids [MAX_POSITIONS];
    logic [ID_W-1:0]      r_max_ids [MAX_POSITIONS];
    logic [POS_CNT_W-1:0] r_min_cnt, r_max_cnt;

    logic [DOSE_W+FRAC_W+DOSE_W-1:0] w_ddf;
    logic min_new, min_add, max_new, max_add;

    assign w_ddf   = r_dd * r_f;
    assign min_new = !r_seen || (r_d < r_min);
    assign min_add = (r_d == r_min) && (r_min_cnt < POS_CNT_W'(MAX_POSITIONS));
    assign max_new = !r_seen || (r_d > r_max);
    assign max_add = (r_d == r_max) && (r_max_cnt < POS_CNT_W'(MAX_POSITIONS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_op == OP_CLEAR) begin
            r_s       <= '0;
            r_q       <= '0;
            r_fs      <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_seen    <= 1'b0;
            r_min_cnt <= '0;
            r_max_cnt <= '0;
        end else if (i_op == OP_ACC) begin
            r_s    <= r_s + SUM_W'(r_df);
            r_q    <= r_q + SQ_W'(w_ddf);
            r_fs   <= r_fs + FSUM_W'(r_f);
            r_seen <= 1'b1;
            if (min_new) begin
                r_min     <= r_d;
                r_min_cnt <= POS_CNT_W'(1);
            end else if (min_add) begin
                r_min_cnt <= r_min_cnt + 1'b1;
            end
            if (max_new) begin
                r_max     <= r_d;
                r_max_cnt <= POS_CNT_W'(1);
            end else if (max_add) begin
                r_max_cnt <= r_max_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_ACC) begin
            if (min_new) begin
                r_min_ids[0] <= r_id;
            end else if (min_add) begin
                r_min_ids[r_min_cnt[POS_IDX_W-1:0]] <= r_id;
            end
            if (max_new) begin
                r_max_ids[0] <= r_id;
            end else if (max_add) begin
                r_max_ids[r_max_cnt[POS_IDX_W-1:0]] <= r_id;
            end
        end
    end

    // shared step counter
    logic [STEP_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (i_op) inside
                OP_MQF_GO:  r_cnt <= STEP_W'(FSUM_W);
                OP_MSS_GO:  r_cnt <= STEP_W'(SUM_W);
                OP_DIVM_GO, OP_DIVV_GO: r_cnt <= STEP_W'(PROD_W);
                OP_SQRT_GO: r_cnt <= STEP_W'(SQRT_STEPS);
                OP_STEP_MUL, OP_STEP_DIV, OP_STEP_SQRT: r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    // shift-add multiplier: Q*F first, then S*S
    logic [PROD_W-1:0] r_mc, r_prod, r_qf, r_num;
    logic [MP_W-1:0]   r_mp;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_MQF_GO: begin
                r_mc   <= PROD_W'(r_q);
                r_mp   <= MP_W'(r_fs);
                r_prod <= '0;
            end
            OP_MSS_GO: begin
                r_qf   <= r_prod;
                r_mc   <= PROD_W'(r_s);
                r_mp   <= MP_W'(r_s);
                r_prod <= '0;
            end
            OP_STEP_MUL: begin
                if (r_mp[0]) r_prod <= r_prod + r_mc;
                r_mc <= {r_mc[PROD_W-2:0], 1'b0};
                r_mp <= r_mp >> 1;
            end
            OP_SUB: r_num <= (r_qf >= r_prod) ? r_qf - r_prod : '0;
            default: ;
        endcase
    end

    // restoring divider, one quotient bit a cycle
    logic [PROD_W-1:0] r_dvd, r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    r_rem;
    logic [DVS_W:0]    w_trial;
    logic              w_fits;

    assign w_trial = {r_rem[DVS_W-1:0], r_dvd[PROD_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_DIVM_GO: begin
                r_dvd <= PROD_W'(r_s);
                r_dvs <= DVS_W'(r_fs);
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_DIVV_GO: begin
                r_dvd <= r_num;
                r_dvs <= r_fs * r_fs;
                r_rem <= '0;
                r_quo <= '0;
            end
            OP_STEP_DIV: begin
                r_rem <= w_fits ? w_trial - {1'b0, r_dvs} : w_trial;
                r_quo <= {r_quo[PROD_W-2:0], w_fits};
                r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    // square root of the low 32 quotient bits
    logic [31:0] r_sv, r_res, r_bit;
    logic [32:0] w_rb;
    logic        r_var_big, r_var_ge;
    logic [DOSE_W-1:0] r_mean, r_dev;

    assign w_rb = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_MEAN: begin
                r_mean <= (|r_quo[PROD_W-1:DOSE_W]) ? '1 : r_quo[DOSE_W-1:0];
            end
            OP_SQRT_GO: begin
                r_sv      <= r_quo[31:0];
                r_res     <= '0;
                r_bit     <= 32'h4000_0000;
                r_var_big <= |r_quo[PROD_W-1:32];
                r_var_ge  <= r_quo[31:0] >= r_floor;
            end
            OP_STEP_SQRT: begin
                if ({1'b0, r_sv} >= w_rb) begin
                    r_sv  <= r_sv - w_rb[31:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DEV: begin
                if (r_fs < FSUM_W'(TWO_VOXELS)) r_dev <= '0;
                else if (r_var_big) r_dev <= '1;
                else if (r_var_ge) r_dev <= r_res[DOSE_W-1:0];
                else r_dev <= '0;
                if (r_fs == '0) r_mean <= '0;
            end
            default: ;
        endcase
    end

    // emission
    logic [EMIT_W-1:0]  r_eidx, w_nmin, w_nmax, w_mi, w_xi;
    logic [WANT_W-1:0]  w_mw, w_xw;
    logic [FSUM_W+VVOL_W-1:0] w_volp;
    logic [FSUM_W+VVOL_W-13:0] w_vols;
    logic [VOL_W-1:0]   w_vol;

    always_comb begin
        w_mw = (r_min_want > WANT_W'(MAX_POSITIONS)) ? WANT_W'(MAX_POSITIONS) : r_min_want;
        w_xw = (r_max_want > WANT_W'(MAX_POSITIONS)) ? WANT_W'(MAX_POSITIONS) : r_max_want;
        w_nmin = (EMIT_W'(w_mw) > EMIT_W'(r_min_cnt)) ? EMIT_W'(r_min_cnt) : EMIT_W'(w_mw);
        w_nmax = (EMIT_W'(w_xw) > EMIT_W'(r_max_cnt)) ? EMIT_W'(r_max_cnt) : EMIT_W'(w_xw);
        w_mi   = r_eidx - 1'b1;
        w_xi   = r_eidx - 1'b1 - w_nmin;
        w_volp = r_fs * r_vvol;
        w_vols = w_volp[FSUM_W+VVOL_W-1:12];
        w_vol  = (w_vols > (FSUM_W+VVOL_W-12)'({VOL_W{1'b1}})) ? '1 : w_vols[VOL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_op == OP_CLEAR) begin
            r_eidx <= '0;
        end else if (i_op == OP_NEXT) begin
            r_eidx <= r_eidx + 1'b1;
        end
    end

    logic [OUT_DATA_W-1:0] r_data, w_word;
    logic [1:0]            r_kind, w_kind;
    logic                  r_olast;

    always_comb begin
        w_word = '0;
        if (r_eidx == '0) begin
            w_kind          = KIND_STAT;
            w_word[15:0]    = r_min;
            w_word[31:16]   = r_max;
            w_word[47:32]   = r_mean;
            w_word[63:48]   = r_dev;
            w_word[92:64]   = WCNT_W'(r_fs);
            w_word[124:93]  = w_vol;
            w_word[125]     = r_fs == '0;
        end else if (r_eidx <= w_nmin) begin
            w_kind          = KIND_MIN;
            w_word[157:126] = r_min_ids[w_mi[POS_IDX_W-1:0]];
        end else begin
            w_kind          = KIND_MAX;
            w_word[157:126] = r_max_ids[w_xi[POS_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_olast <= r_eidx == (w_nmin + w_nmax);
            r_data  <= w_word;
            r_kind  <= w_kind;
        end
    end

    assign o_st.last      = r_last;
    assign o_st.done      = r_cnt == '0;
    assign o_st.emit_last = r_olast;
    assign o_data         = r_data;
    assign o_kind         = r_kind;
    assign o_last         = r_olast;

endmodule

/* rtl/weighted_dose_statistics.sv */
// Top level of the weighted dose statistics block.
// Voxels arrive one word at a time; each is first captured with the dose
// products, then accumulated into the sums and the extremes. After the word
// with tlast the block runs the finishing arithmetic on shared iterative
// units: a shift-add multiplier (Q*F, then S*S), a restoring divider for the
// mean and the variance and a bit-pair square root, then sends one
// statistics word followed by the minimum and maximum id words, each of
// which can be held by an output stall. No new voxel is taken until the
// last result word of a set has been delivered.
module weighted_dose_statistics (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // dose[15:0], fraction[28:16], voxel_id[60:29], zero fill
    input  logic [wds_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // minimum_dose[15:0], maximum_dose[31:16], mean_dose[47:32],
    // deviation_dose[63:48], weighted_count[92:64], total_volume[124:93],
    // empty_set[125], position_id[157:126], zero fill
    output logic [wds_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // kind[1:0]
    output logic [1:0]                      o_m_tuser,
    output logic                            o_m_tlast
);
    import wds_pkg::*;

    t_op     w_op;
    t_status w_st;

    wds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_st        (w_st),
        .o_op        (w_op)
    );

    wds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_dose       (i_s_tdata[15:0]),
        .i_fraction   (i_s_tdata[28:16]),
        .i_voxel_id   (i_s_tdata[60:29]),
        .i_last_voxel (i_s_tlast),
        .i_op         (w_op),
        .o_st         (w_st),
        .o_data       (o_m_tdata),
        .o_kind       (o_m_tuser),
        .o_last       (o_m_tlast)
    );

endmodule
